### hdl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// shared types and constants of the bounded lifo stack
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned DEPTH_DEF   = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned MAX_DEPTH_W = 6;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  // register file: one register, selected by address bit 2
  localparam logic REG_MAX_DEPTH = 1'b0;
  localparam logic [MAX_DEPTH_W-1:0] MAX_DEPTH_RST = 6'd32;

  // raw request codes on the mode port
  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_DISPLAY = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // classified operations handed to the back end
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISPLAY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_POPPED    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE     = 2'd0,
    BK_POP_WAIT = 2'd1,
    BK_DISPLAY  = 2'd2
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

### hdl/bls_ram.sv
// ----------------------------------------------------------------------------
// bls_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/bls_front.sv
// ----------------------------------------------------------------------------
// bls_front
// request decode and two-entry command queue
// ----------------------------------------------------------------------------
module bls_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                mode,
  input  logic [bls_pkg::DATA_W-1:0] push_value,
  output logic                      busy,
  output bls_pkg::queue_head_t      head,
  input  logic                      take
);

  bls_pkg::cmd_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          op_ok;
  bls_pkg::op_t  op;
  logic          enq;

  // unused mode code is dropped here, it has no result
  always_comb begin
    op_ok = 1'b1;
    op    = bls_pkg::OP_PUSH;
    unique case (bls_pkg::mode_t'(mode))
      bls_pkg::MODE_PUSH:    op = bls_pkg::OP_PUSH;
      bls_pkg::MODE_POP:     op = bls_pkg::OP_POP;
      bls_pkg::MODE_DISPLAY: op = bls_pkg::OP_DISPLAY;
      default:               op_ok = 1'b0;
    endcase
  end

  assign busy       = (count == 2'd2);
  assign enq        = start && !busy && op_ok;
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({enq, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slot[wr_ptr] <= '{op: op, value: push_value};
    end
  end

endmodule

### hdl/bls_back.sv
// ----------------------------------------------------------------------------
// bls_back
// executes stack commands against the entry ram and the fill count
// ----------------------------------------------------------------------------
module bls_back #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bls_pkg::queue_head_t            head,
  output logic                            take,
  input  logic [bls_pkg::MAX_DEPTH_W-1:0] max_depth,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [bls_pkg::DATA_W-1:0]      data_out,
  output logic                            last,
  output logic [CW-1:0]                   fill
);

  localparam int unsigned CMPW = (CW > bls_pkg::MAX_DEPTH_W) ? CW : bls_pkg::MAX_DEPTH_W;

  bls_pkg::back_state_t       state, state_next;
  logic [CW-1:0]              fill_next;
  logic [AW-1:0]              idx, idx_next;
  logic                       done_next;
  bls_pkg::status_t           status_q, status_next;
  logic [bls_pkg::DATA_W-1:0] data_next;
  logic                       last_next;

  logic                       wr_en;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [bls_pkg::DATA_W-1:0] rd_data;
  logic                       full;
  logic [CW-1:0]              fill_dec;
  logic [CW-1:0]              idx_inc;

  // capacity is min(max_depth, DEPTH)
  assign full = (CMPW'(fill) >= CMPW'(max_depth)) || (fill == CW'(DEPTH));
  assign fill_dec = fill - CW'(1);
  assign idx_inc  = CW'(idx) + CW'(1);

  bls_ram #(
    .WIDTH (bls_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[AW-1:0]),
    .wr_data (head.cmd.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    idx_next    = idx;
    take        = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx;
    done_next   = 1'b0;
    status_next = bls_pkg::ST_PUSHED;
    data_next   = '0;
    last_next   = 1'b1;
    unique case (state)
      bls_pkg::BK_IDLE: begin
        if (head.valid) begin
          take = 1'b1;
          unique case (head.cmd.op)
            bls_pkg::OP_PUSH: begin
              done_next = 1'b1;
              if (full) begin
                status_next = bls_pkg::ST_OVERFLOW;
              end else begin
                wr_en       = 1'b1;
                fill_next   = fill + CW'(1);
                status_next = bls_pkg::ST_PUSHED;
              end
            end
            bls_pkg::OP_POP: begin
              if (fill == '0) begin
                done_next   = 1'b1;
                status_next = bls_pkg::ST_UNDERFLOW;
              end else begin
                fill_next  = fill_dec;
                rd_en      = 1'b1;
                rd_addr    = fill_dec[AW-1:0];
                state_next = bls_pkg::BK_POP_WAIT;
              end
            end
            bls_pkg::OP_DISPLAY: begin
              if (fill == '0) begin
                done_next   = 1'b1;
                status_next = bls_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = bls_pkg::BK_DISPLAY;
              end
            end
            default: ;
          endcase
        end
      end
      bls_pkg::BK_POP_WAIT: begin
        done_next   = 1'b1;
        status_next = bls_pkg::ST_POPPED;
        data_next   = rd_data;
        state_next  = bls_pkg::BK_IDLE;
      end
      bls_pkg::BK_DISPLAY: begin
        // one entry a cycle, next read issued while this one is shown
        done_next   = 1'b1;
        status_next = bls_pkg::ST_ENTRY;
        data_next   = rd_data;
        last_next   = (idx_inc == fill);
        if (idx_inc == fill) begin
          state_next = bls_pkg::BK_IDLE;
        end else begin
          idx_next = idx + AW'(1);
          rd_en    = 1'b1;
          rd_addr  = idx + AW'(1);
        end
      end
      default: state_next = bls_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bls_pkg::BK_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    status_q <= status_next;
    data_out <= data_next;
    last     <= last_next;
  end

  assign status = status_q;

endmodule

### hdl/bounded_lifo_stack.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// bounded last-in-first-out stack of signed 32-bit words
// ----------------------------------------------------------------------------
// usage
//   requests: drive mode and push_value with start high; the item is taken at
//   a clock edge where start is high and busy is low. mode 0 pushes, 1 pops,
//   2 shows every stored word bottom to top, 3 is dropped with no result
//   results: each result sits on status, data_out and last for one cycle
//   with done high; the receiver cannot hold them off. last marks the final
//   result of an item; a display gives one result per stored word, or one
//   empty result when nothing is stored
//   a result comes from the back end's result registers after the item has
//   passed the command queue; a pop or display also waits on the registered
//   ram read, and the later displayed words follow one a cycle
//   throughput: push one item a cycle while the back end is idle; a pop or a
//   display keeps the back end from taking a new item until its last result,
//   as it has a single ram read port. a two-item queue sits between the decode
//   front and the back end; busy is high while that queue is full
//   config: max_depth at byte address 0 over the apb port, to be written only
//   when the block is idle (not enforced here); capacity is min(max_depth, DEPTH)
//   reset: queue emptied, stack empty, max_depth back to 32; the entry ram
//   is not cleared since only words below the fill count are ever read
// ----------------------------------------------------------------------------
module bounded_lifo_stack #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bls_pkg::PADDR_W-1:0]  paddr,
  input  logic [bls_pkg::PDATA_W-1:0]  pwdata,
  output logic [bls_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // request channel
  input  logic                         start,
  input  logic [1:0]                   mode,
  input  logic signed [bls_pkg::DATA_W-1:0] push_value,
  output logic                         busy,
  // result channel
  output logic                         done,
  output logic [2:0]                   status,
  output logic signed [bls_pkg::DATA_W-1:0] data_out,
  output logic                         last
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [bls_pkg::MAX_DEPTH_W-1:0] max_depth;
  logic                            cfg_wr;
  logic                            reg_sel;
  bls_pkg::queue_head_t            head;
  logic                            take;
  logic [CW-1:0]                   fill;
  logic [bls_pkg::DATA_W-1:0]      data_raw;

  // apb: no wait states, one register selected by address bit 2
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == bls_pkg::REG_MAX_DEPTH);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? bls_pkg::PDATA_W'(max_depth) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth <= bls_pkg::MAX_DEPTH_RST;
    end else if (cfg_wr) begin
      max_depth <= pwdata[bls_pkg::MAX_DEPTH_W-1:0];
    end
  end

  // front: decode and queue the item
  bls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .push_value (push_value),
    .busy       (busy),
    .head       (head),
    .take       (take)
  );

  // back: stack update, ram access and result registers
  bls_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .take      (take),
    .max_depth (max_depth),
    .done      (done),
    .status    (status),
    .data_out  (data_raw),
    .last      (last),
    .fill      (fill)
  );

  assign data_out = data_raw;

`ifndef SYNTHESIS
  // fill count never goes past the built depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above depth");

  // fill count moves by at most one per cycle
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fill == $past(fill) || fill == CW'($past(fill) + 1'b1) ||
                     fill == CW'($past(fill) - 1'b1)))
    else $error("fill count jumped");

  // only a display run has results that are not last
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> status == bls_pkg::ST_ENTRY)
    else $error("non-final result outside display");

  // push, pop, underflow, overflow and empty are single results
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    done && status != bls_pkg::ST_ENTRY |-> last)
    else $error("single result without last");
`endif

endmodule

### bench/bounded_lifo_stack_test.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack_test
// self-checking bench for the bounded lifo stack: requests go in through a
// start/busy handshake, the max_depth register is set over the apb port
// between phases, and every done strobe is checked against a behavioural
// stack kept alongside the design
// ----------------------------------------------------------------------------
module bounded_lifo_stack_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = bls_pkg::DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [bls_pkg::PADDR_W-1:0] ADDR_MAX_DEPTH = {bls_pkg::REG_MAX_DEPTH, 2'b00};

  // one request as presented on the command port
  typedef struct packed {
    bls_pkg::mode_t                     mode;
    logic signed [bls_pkg::DATA_W-1:0]  value;
  } request_t;

  // one result as it should appear on the result ports
  typedef struct packed {
    bls_pkg::status_t                   status;
    logic signed [bls_pkg::DATA_W-1:0]  data;
    logic                               last;
  } outcome_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // apb side, owned by the phase sequencer
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [bls_pkg::PADDR_W-1:0]  paddr   = '0;
  logic [bls_pkg::PDATA_W-1:0]  pwdata  = '0;
  logic [bls_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  // request side, owned by the driver
  logic                                start      = 1'b0;
  logic [1:0]                          mode       = 2'd0;
  logic signed [bls_pkg::DATA_W-1:0]   push_value = '0;
  logic                                busy;

  // result side
  logic                                done;
  logic [2:0]                          status;
  logic signed [bls_pkg::DATA_W-1:0]   data_out;
  logic                                last;

  // traffic between sequencer, driver and checker
  request_t request_queue[$];
  outcome_t awaited_results[$];
  request_t presented_request;
  int unsigned sender_idle_pct = 0;

  // behavioural copy of the stack
  logic signed [bls_pkg::DATA_W-1:0] stack_words [STACK_DEPTH];
  int unsigned                       stack_fill = 0;
  logic [bls_pkg::MAX_DEPTH_W-1:0]   depth_limit = bls_pkg::MAX_DEPTH_RST;

  // bookkeeping
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned accepted_count = 0;
  int unsigned ignored_count = 0;
  int unsigned result_count = 0;
  int unsigned status_count [8];

  bounded_lifo_stack DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start      (start),
    .mode       (mode),
    .push_value (push_value),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .data_out   (data_out),
    .last       (last)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // behavioural stack: works out the results one accepted request causes
  // ---------------------------------------------------------------------------
  task automatic apply_stack_request(input request_t req);
    int unsigned room;
    room = (depth_limit > STACK_DEPTH) ? STACK_DEPTH : depth_limit;
    case (req.mode)
      bls_pkg::MODE_PUSH: begin
        if (stack_fill >= room) begin
          awaited_results.push_back('{bls_pkg::ST_OVERFLOW, '0, 1'b1});
        end else begin
          stack_words[stack_fill] = req.value;
          stack_fill++;
          awaited_results.push_back('{bls_pkg::ST_PUSHED, '0, 1'b1});
        end
      end
      bls_pkg::MODE_POP: begin
        // an empty pop leaves the stack alone
        if (stack_fill == 0) begin
          awaited_results.push_back('{bls_pkg::ST_UNDERFLOW, '0, 1'b1});
        end else begin
          stack_fill--;
          awaited_results.push_back('{bls_pkg::ST_POPPED, stack_words[stack_fill], 1'b1});
        end
      end
      bls_pkg::MODE_DISPLAY: begin
        // bottom to top, last flag on the top word
        if (stack_fill == 0) begin
          awaited_results.push_back('{bls_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          for (int unsigned i = 0; i < stack_fill; i++) begin
            awaited_results.push_back('{bls_pkg::ST_ENTRY, stack_words[i],
                                        i + 1 == stack_fill});
          end
        end
      end
      default: ignored_count++;  // unused mode: no result, no change
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued requests, holds them while busy, and inserts
  // random gaps at the rate the current phase asks for
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic take_next;
    take_next = 1'b0;
    if (!rst) begin
      // item taken at this edge
      if (start && !busy) begin
        apply_stack_request(presented_request);
        accepted_count++;
      end
      // free to present something new
      if (!start || !busy) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          take_next = 1'b1;
        end
        if (take_next) begin
          presented_request = request_queue.pop_front();
          start      <= 1'b1;
          mode       <= presented_request.mode;
          push_value <= presented_request.value;
        end else begin
          // junk on the request fields while start is low
          start      <= 1'b0;
          mode       <= 2'($urandom);
          push_value <= $urandom;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every strobed result against the oldest awaited one
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done) begin
      result_count++;
      status_count[status]++;
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, got status %0d data 0x%08h last %0b",
                 $time, status, data_out, last);
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("data_out", want.data, data_out);
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // overall watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly uniform words, with the corner values now and then
  function automatic logic signed [bls_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_request(input bls_pkg::mode_t m,
                                        input logic signed [bls_pkg::DATA_W-1:0] v);
    request_queue.push_back('{m, v});
  endfunction

  // wait until the design has nothing in flight, then let it settle
  task automatic wait_until_idle();
    while (request_queue.size() != 0 || start || awaited_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write of max_depth: setup cycle, then access until pready
  task automatic write_max_depth(input logic [bls_pkg::MAX_DEPTH_W-1:0] limit);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_DEPTH;
    pwdata  <= bls_pkg::PDATA_W'(limit);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom;
    depth_limit = limit;
    @(negedge clk);
  endtask

  // runs of push-heavy, pop-heavy and balanced traffic so that the stack
  // swings between empty and full; unused modes do not count
  task automatic queue_stack_traffic(input int unsigned count);
    int unsigned queued;
    int unsigned run_left;
    int unsigned push_pct;
    int unsigned roll;
    queued = 0;
    run_left = 0;
    push_pct = 50;
    while (queued < count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 16);
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        queue_request(bls_pkg::MODE_UNUSED, pick_word());
      end else begin
        if (roll < 10) queue_request(bls_pkg::MODE_DISPLAY, pick_word());
        else if ($urandom_range(99) < push_pct) queue_request(bls_pkg::MODE_PUSH, pick_word());
        else queue_request(bls_pkg::MODE_POP, pick_word());
        queued++;
        run_left--;
      end
    end
  endtask

  // one phase: new capacity and gap rate, an optional fill burst, then random traffic
  task automatic run_phase(input logic [bls_pkg::MAX_DEPTH_W-1:0] limit,
                           input int unsigned idle_pct,
                           input bit fill_first, input int unsigned count);
    wait_until_idle();
    write_max_depth(limit);
    sender_idle_pct = idle_pct;
    // drive past the built depth, then show the whole stack
    if (fill_first) begin
      repeat (STACK_DEPTH + 2) queue_request(bls_pkg::MODE_PUSH, pick_word());
      queue_request(bls_pkg::MODE_DISPLAY, pick_word());
    end
    queue_stack_traffic(count);
  endtask

  // ---------------------------------------------------------------------------
  // phase sequencer
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty stack cases, corner words, ignored mode, display and
    // pops with a junk value, all at the reset capacity
    sender_idle_pct = 0;
    queue_request(bls_pkg::MODE_POP, 32'h5a5a_5a5a);
    queue_request(bls_pkg::MODE_DISPLAY, 32'h0000_0000);
    queue_request(bls_pkg::MODE_PUSH, 32'h7fff_ffff);
    queue_request(bls_pkg::MODE_PUSH, 32'h8000_0000);
    queue_request(bls_pkg::MODE_PUSH, 32'h0000_0000);
    queue_request(bls_pkg::MODE_PUSH, 32'hffff_ffff);
    queue_request(bls_pkg::MODE_UNUSED, 32'h1234_5678);
    queue_request(bls_pkg::MODE_DISPLAY, 32'hffff_ffff);
    queue_request(bls_pkg::MODE_POP, 32'hffff_ffff);
    queue_request(bls_pkg::MODE_POP, 32'h0000_0000);
    queue_request(bls_pkg::MODE_PUSH, 32'h1234_5678);
    queue_request(bls_pkg::MODE_DISPLAY, 32'h8000_0000);
    queue_request(bls_pkg::MODE_UNUSED, 32'hffff_ffff);
    queue_request(bls_pkg::MODE_PUSH, 32'hedcb_a987);

    // capacity of one with words already above it
    run_phase(6'd1, 0, 1'b0, 40);
    // zero capacity: every push overflows
    run_phase(6'd0, 74, 1'b0, 25);
    // register above the build saturates to the built depth
    run_phase(6'd63, 0, 1'b1, 50);
    // some capacity in between, light gaps
    run_phase(6'($urandom_range(2, 31)), 17, 1'b0, 60);
    // back to the built depth under heavy gaps
    run_phase(6'd32, 74, 1'b1, 50);

    wait_until_idle();

    $display("requests taken %0d (%0d ignored), results %0d: pushed %0d overflow %0d",
             accepted_count, ignored_count, result_count,
             status_count[bls_pkg::ST_PUSHED], status_count[bls_pkg::ST_OVERFLOW]);
    $display("popped %0d underflow %0d entries %0d empty %0d, capacities 32/1/0/63/mid/32",
             status_count[bls_pkg::ST_POPPED], status_count[bls_pkg::ST_UNDERFLOW],
             status_count[bls_pkg::ST_ENTRY], status_count[bls_pkg::ST_EMPTY]);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
